// ===== design/unix_seconds_to_calendar_defines.svh =====
// Assertion macros used by the calendar converter controller.
`ifndef UNIX_SECONDS_TO_CALENDAR_DEFINES_SVH
`define UNIX_SECONDS_TO_CALENDAR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define USTC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define USTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define USTC_ASSERT_IMP(label, ante, cons, msg)
`define USTC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== design/ustc_pkg.sv =====
// Types, codes, constants and helper functions for the calendar converter.
package ustc_pkg;

  // Datapath operation codes issued by the controller.
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_STEP   = 3'd2;
  localparam logic [2:0] OP_NEXT   = 3'd3;
  localparam logic [2:0] OP_YEAR   = 3'd4;
  localparam logic [2:0] OP_MONTH  = 3'd5;
  localparam logic [2:0] OP_FINISH = 3'd6;

  // Division phases, one per constant divisor.
  localparam logic [1:0] PH_DAY  = 2'd0;
  localparam logic [1:0] PH_WDAY = 2'd1;
  localparam logic [1:0] PH_HOUR = 2'd2;
  localparam logic [1:0] PH_MIN  = 2'd3;

  // Divisors, all below 2**17.
  localparam logic [16:0] DIV_DAY  = 17'd86400;
  localparam logic [16:0] DIV_WDAY = 17'd7;
  localparam logic [16:0] DIV_HOUR = 17'd3600;
  localparam logic [16:0] DIV_MIN  = 17'd60;

  // Truncated reciprocals. Each dividend stays below the matching power of two,
  // so the estimated quotient is either exact or one short.
  localparam logic [15:0] RCP_DAY  = 16'd49710;  // floor(2**32 / 86400)
  localparam logic [15:0] RCP_WDAY = 16'd9362;   // floor(2**16 / 7)
  localparam logic [15:0] RCP_HOUR = 16'd36;     // floor(2**17 / 3600)
  localparam logic [15:0] RCP_MIN  = 16'd68;     // floor(2**12 / 60)

  // Steps each division runs before its correction: the first forms the
  // reciprocal product, the second the quotient and remainder estimates.
  localparam logic [5:0] STEPS_DAY  = 6'd2;
  localparam logic [5:0] STEPS_WDAY = 6'd2;
  localparam logic [5:0] STEPS_HOUR = 6'd2;
  localparam logic [5:0] STEPS_MIN  = 6'd2;

  // Calendar constants.
  localparam logic [7:0]  EPOCH_YEAR_OFS = 8'd70;   // 1970 - 1900
  localparam logic [7:0]  YEAR_2100_OFS  = 8'd200;  // 2100 - 1900
  localparam logic [15:0] EPOCH_WDAY_OFS = 16'd4;   // 1970-01-01 was a Thursday
  localparam logic [3:0]  LAST_MONTH     = 4'd11;

  // Controller to datapath command.
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] phase;
  } ustc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic year_more;
    logic month_more;
  } ustc_sts_t;

  // Leap rule over the reachable years 1970 to 2106: the only century years
  // in that span are 2000, which is divisible by 400, and 2100, which is not.
  function automatic logic is_leap(input logic [7:0] yofs);
    logic leap;
    leap = (yofs[1:0] == 2'd0) && (yofs != YEAR_2100_OFS);
    return leap;
  endfunction

  // Days in a month, February lengthened in a leap year.
  function automatic logic [4:0] month_len(input logic [3:0] m0, input logic leap);
    logic [4:0] len;
    case (m0)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== design/ustc_if.sv =====
// Valid/ready channel interfaces for the timestamp input and the calendar result.
interface ustc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface ustc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] second;
  logic [5:0] minute;
  logic [4:0] hour;
  logic [4:0] day_of_month;
  logic [3:0] month_index;
  logic [7:0] years_since_1900;
  logic [2:0] weekday;

  modport source (output valid, output second, output minute, output hour,
                  output day_of_month, output month_index, output years_since_1900,
                  output weekday, input ready);
  modport sink   (input valid, input second, input minute, input hour,
                  input day_of_month, input month_index, input years_since_1900,
                  input weekday, output ready);
endinterface

// ===== design/ustc_dp.sv =====
// Datapath: reciprocal dividers, year and month peeling, result register.
module ustc_dp (
  input  logic               clk,
  input  logic [31:0]        unix_seconds,
  input  logic               hour_mode,
  input  ustc_pkg::ustc_cmd_t cmd,
  output ustc_pkg::ustc_sts_t sts,
  output logic [5:0]         second,
  output logic [5:0]         minute,
  output logic [4:0]         hour,
  output logic [4:0]         day_of_month,
  output logic [3:0]         month_index,
  output logic [7:0]         years_since_1900,
  output logic [2:0]         weekday
);

  logic [31:0] num_r, num_nxt;
  logic [47:0] prod_r, prod_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [15:0] days_r, days_nxt;
  logic [16:0] secs_r, secs_nxt;
  logic [7:0]  year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [2:0]  wday_r, wday_nxt;

  logic [5:0]  out_second_r, out_second_nxt;
  logic [5:0]  out_minute_r, out_minute_nxt;
  logic [4:0]  out_hour_r, out_hour_nxt;
  logic [4:0]  out_mday_r, out_mday_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [7:0]  out_year_r, out_year_nxt;
  logic [2:0]  out_wday_r, out_wday_nxt;

  logic [16:0] divisor;
  logic [15:0] recip;
  logic [15:0] quo_est;
  logic [31:0] back_prod;
  logic [31:0] rem_est;
  logic        ge;
  logic [15:0] quo_fix;
  logic [17:0] rem_fix;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [4:0]  hour_shown;

  // Divisor, reciprocal and product scaling for the phase in progress.
  always_comb begin
    case (cmd.phase)
      ustc_pkg::PH_DAY: begin
        divisor = ustc_pkg::DIV_DAY;
        recip   = ustc_pkg::RCP_DAY;
        quo_est = prod_r[47:32];
      end
      ustc_pkg::PH_WDAY: begin
        divisor = ustc_pkg::DIV_WDAY;
        recip   = ustc_pkg::RCP_WDAY;
        quo_est = prod_r[31:16];
      end
      ustc_pkg::PH_HOUR: begin
        divisor = ustc_pkg::DIV_HOUR;
        recip   = ustc_pkg::RCP_HOUR;
        quo_est = prod_r[32:17];
      end
      default: begin
        divisor = ustc_pkg::DIV_MIN;
        recip   = ustc_pkg::RCP_MIN;
        quo_est = prod_r[27:12];
      end
    endcase
  end

  // The estimate is never above the true quotient, so the remainder estimate
  // lies below twice the divisor and one compare and subtract finishes it.
  assign back_prod = {16'd0, quo_est} * {15'd0, divisor};
  assign rem_est   = num_r - back_prod;
  assign ge        = rem_r >= {1'b0, divisor};
  assign quo_fix   = quo_r + {15'd0, ge};
  assign rem_fix   = ge ? (rem_r - {1'b0, divisor}) : rem_r;

  // Lengths of the current year and month.
  assign leap = ustc_pkg::is_leap(year_r);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = ustc_pkg::month_len(month_r, leap);

  assign sts.year_more  = days_r >= {7'd0, ylen};
  assign sts.month_more = (month_r < ustc_pkg::LAST_MONTH) && (days_r >= {11'd0, mlen});

  // Twelve-hour mapping: midnight shows as 12, afternoon hours drop by 12.
  always_comb begin
    hour_shown = hour_r;
    if (!hour_mode) begin
      if (hour_r == 5'd0) begin
        hour_shown = 5'd12;
      end else if (hour_r > 5'd12) begin
        hour_shown = hour_r - 5'd12;
      end
    end
  end

  // Next-state logic of the working registers.
  always_comb begin
    num_nxt    = num_r;
    prod_nxt   = prod_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    days_nxt   = days_r;
    secs_nxt   = secs_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    wday_nxt   = wday_r;
    case (cmd.op)
      ustc_pkg::OP_LOAD: begin
        num_nxt   = unix_seconds;
        year_nxt  = ustc_pkg::EPOCH_YEAR_OFS;
        month_nxt = 4'd0;
      end
      ustc_pkg::OP_STEP: begin
        // Product and estimates form a two-stage pipeline over a steady dividend.
        prod_nxt = {16'd0, num_r} * {32'd0, recip};
        quo_nxt  = quo_est;
        rem_nxt  = rem_est[17:0];
      end
      ustc_pkg::OP_NEXT: begin
        case (cmd.phase)
          ustc_pkg::PH_DAY: begin
            // Day count and seconds of the day; weekday counts from a Thursday.
            days_nxt = quo_fix;
            secs_nxt = rem_fix[16:0];
            num_nxt  = {16'd0, quo_fix + ustc_pkg::EPOCH_WDAY_OFS};
          end
          ustc_pkg::PH_WDAY: begin
            wday_nxt = rem_fix[2:0];
            num_nxt  = {15'd0, secs_r};
          end
          ustc_pkg::PH_HOUR: begin
            hour_nxt = quo_fix[4:0];
            num_nxt  = {20'd0, rem_fix[11:0]};
          end
          default: begin
            minute_nxt = quo_fix[5:0];
            second_nxt = rem_fix[5:0];
          end
        endcase
      end
      ustc_pkg::OP_YEAR: begin
        days_nxt = days_r - {7'd0, ylen};
        year_nxt = year_r + 8'd1;
      end
      ustc_pkg::OP_MONTH: begin
        days_nxt  = days_r - {11'd0, mlen};
        month_nxt = month_r + 4'd1;
      end
      default: begin
      end
    endcase
  end

  // Result register, loaded when the item is complete.
  always_comb begin
    out_second_nxt = out_second_r;
    out_minute_nxt = out_minute_r;
    out_hour_nxt   = out_hour_r;
    out_mday_nxt   = out_mday_r;
    out_month_nxt  = out_month_r;
    out_year_nxt   = out_year_r;
    out_wday_nxt   = out_wday_r;
    if (cmd.op == ustc_pkg::OP_FINISH) begin
      out_second_nxt = second_r;
      out_minute_nxt = minute_r;
      out_hour_nxt   = hour_shown;
      out_mday_nxt   = days_r[4:0] + 5'd1;
      out_month_nxt  = month_r;
      out_year_nxt   = year_r;
      out_wday_nxt   = wday_r;
    end
  end

  always_ff @(posedge clk) begin
    num_r        <= num_nxt;
    prod_r       <= prod_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    days_r       <= days_nxt;
    secs_r       <= secs_nxt;
    year_r       <= year_nxt;
    month_r      <= month_nxt;
    hour_r       <= hour_nxt;
    minute_r     <= minute_nxt;
    second_r     <= second_nxt;
    wday_r       <= wday_nxt;
    out_second_r <= out_second_nxt;
    out_minute_r <= out_minute_nxt;
    out_hour_r   <= out_hour_nxt;
    out_mday_r   <= out_mday_nxt;
    out_month_r  <= out_month_nxt;
    out_year_r   <= out_year_nxt;
    out_wday_r   <= out_wday_nxt;
  end

  assign second           = out_second_r;
  assign minute           = out_minute_r;
  assign hour             = out_hour_r;
  assign day_of_month     = out_mday_r;
  assign month_index      = out_month_r;
  assign years_since_1900 = out_year_r;
  assign weekday          = out_wday_r;

endmodule

// ===== design/ustc_ctrl.sv =====
// Controller: sequences divisions, year and month peeling, and the result handshake.
`include "unix_seconds_to_calendar_defines.svh"

module ustc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ustc_pkg::ustc_sts_t sts,
  output ustc_pkg::ustc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV_DAY  = 3'd1;
  localparam logic [2:0] S_DIV_WDAY = 3'd2;
  localparam logic [2:0] S_DIV_HOUR = 3'd3;
  localparam logic [2:0] S_DIV_MIN  = 3'd4;
  localparam logic [2:0] S_YEAR     = 3'd5;
  localparam logic [2:0] S_MONTH    = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The result register can take a new item when empty or being emptied.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Sequencer: divisions run their step counts and store; then year, month, finish.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = ustc_pkg::OP_NONE;
    cmd.phase = ustc_pkg::PH_DAY;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = ustc_pkg::OP_LOAD;
          state_nxt = S_DIV_DAY;
          cnt_nxt   = ustc_pkg::STEPS_DAY;
        end
      end
      S_DIV_DAY: begin
        cmd.phase = ustc_pkg::PH_DAY;
        if (cnt_r != 6'd0) begin
          cmd.op  = ustc_pkg::OP_STEP;
          cnt_nxt = cnt_r - 6'd1;
        end else begin
          cmd.op    = ustc_pkg::OP_NEXT;
          state_nxt = S_DIV_WDAY;
          cnt_nxt   = ustc_pkg::STEPS_WDAY;
        end
      end
      S_DIV_WDAY: begin
        cmd.phase = ustc_pkg::PH_WDAY;
        if (cnt_r != 6'd0) begin
          cmd.op  = ustc_pkg::OP_STEP;
          cnt_nxt = cnt_r - 6'd1;
        end else begin
          cmd.op    = ustc_pkg::OP_NEXT;
          state_nxt = S_DIV_HOUR;
          cnt_nxt   = ustc_pkg::STEPS_HOUR;
        end
      end
      S_DIV_HOUR: begin
        cmd.phase = ustc_pkg::PH_HOUR;
        if (cnt_r != 6'd0) begin
          cmd.op  = ustc_pkg::OP_STEP;
          cnt_nxt = cnt_r - 6'd1;
        end else begin
          cmd.op    = ustc_pkg::OP_NEXT;
          state_nxt = S_DIV_MIN;
          cnt_nxt   = ustc_pkg::STEPS_MIN;
        end
      end
      S_DIV_MIN: begin
        cmd.phase = ustc_pkg::PH_MIN;
        if (cnt_r != 6'd0) begin
          cmd.op  = ustc_pkg::OP_STEP;
          cnt_nxt = cnt_r - 6'd1;
        end else begin
          cmd.op    = ustc_pkg::OP_NEXT;
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (sts.year_more) begin
          cmd.op = ustc_pkg::OP_YEAR;
        end else begin
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (sts.month_more) begin
          cmd.op = ustc_pkg::OP_MONTH;
        end else if (out_free) begin
          cmd.op    = ustc_pkg::OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid flag: set on completion, cleared when the item is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.op == ustc_pkg::OP_FINISH) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A finished item never overwrites a result that is still waiting.
  `USTC_ASSERT_IMP(a_finish_room, cmd.op == ustc_pkg::OP_FINISH, out_free, "result overwritten")
  // A finished item is offered in the following cycle.
  `USTC_ASSERT_NEXT(a_finish_valid, cmd.op == ustc_pkg::OP_FINISH, out_valid_r, "result not offered")
  // An accepted item starts the day division with a full step count.
  `USTC_ASSERT_NEXT(a_start, in_valid && in_ready, (state_r == S_DIV_DAY) && (cnt_r == ustc_pkg::STEPS_DAY), "bad start")
  // The last division hands over to the year loop.
  `USTC_ASSERT_NEXT(a_to_year, (state_r == S_DIV_MIN) && (cnt_r == 6'd0), state_r == S_YEAR, "year loop skipped")

endmodule

// ===== design/unix_seconds_to_calendar.sv =====
// Top level of the Unix seconds to calendar converter.
// Converts a 32-bit unsigned count of seconds since 1970-01-01 00:00:00 into
// second, minute, hour, day of month, month (0 is January), years since 1900
// and weekday (0 is Sunday). One item is worked on at a time. Each of the four
// divisions (by 86400, 7, 3600 and 60) runs a reciprocal product, a quotient
// and remainder estimate, and a one-step correction. Then the elapsed years
// (up to 136, ending in 2106) and months (up to 11) are peeled off one by one.
// The year loop dominates the time to a result, and completion waits while an
// earlier result is still unread. The input is ready again as soon as the
// result is in the output register, so the next item may start while the
// previous result waits. Register hour_mode at address 0 (reset 1) selects
// 24-hour output; 0 selects 12-hour output, where midnight reads 12 and
// afternoon hours read 1 to 11, with no AM/PM indication. Write it only while
// idle.
module unix_seconds_to_calendar (
  input  logic              clk,
  input  logic              rst_n,
  ustc_in_if.sink           in_ch,
  ustc_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic                hour_mode_r, hour_mode_nxt;
  logic                reg_sel;
  ustc_pkg::ustc_cmd_t cmd;
  ustc_pkg::ustc_sts_t sts;

  // Register file: one register, word index taken from the upper address bit.
  assign reg_sel    = (cfg_paddr[2] == 1'b0);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? {31'd0, hour_mode_r} : 32'd0;

  always_comb begin
    hour_mode_nxt = hour_mode_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      hour_mode_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_mode_r <= 1'b1;
    end else begin
      hour_mode_r <= hour_mode_nxt;
    end
  end

  // Sequencer.
  ustc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and result register.
  ustc_dp u_dp (
    .clk              (clk),
    .unix_seconds     (in_ch.unix_seconds),
    .hour_mode        (hour_mode_r),
    .cmd              (cmd),
    .sts              (sts),
    .second           (out_ch.second),
    .minute           (out_ch.minute),
    .hour             (out_ch.hour),
    .day_of_month     (out_ch.day_of_month),
    .month_index      (out_ch.month_index),
    .years_since_1900 (out_ch.years_since_1900),
    .weekday          (out_ch.weekday)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Unix seconds to calendar converter.
module tb;

  // Register addresses on the configuration port.
  localparam logic [2:0] ADDR_HOUR_MODE = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED  = 3'd4;

  // Values of the hour_mode register.
  localparam bit MODE_12H = 1'b0;
  localparam bit MODE_24H = 1'b1;

  localparam longint STAMP_MAX = 64'd4294967295;
  localparam int unsigned SECS_PER_DAY = 86400;

  // One converted calendar item, laid out like the result channel.
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
  } calendar_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ustc_in_if  in_ch ();
  ustc_out_if out_ch ();

  unix_seconds_to_calendar dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Timestamps waiting to be offered and calendars waiting to come out.
  logic [31:0] pending_stamps[$];
  calendar_t   calendar_due[$];

  bit          hour_mode_24 = MODE_24H;
  bit          in_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned fail_count = 0;

  // Gregorian leap rule.
  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(input int m0, input int y);
    int len;
    case (m0)
      1:       len = leap_year(y) ? 29 : 28;
      3, 5, 8, 10: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  // Zeller's congruence with month 1..12, renumbered so that 0 is Sunday.
  function automatic int unsigned weekday_of(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned mm;
    int unsigned yy;
    int unsigned h;
    mm = m;
    yy = y;
    if (mm < 3) begin
      mm = mm + 12;
      yy = yy - 1;
    end
    h = (d + ((mm + 1) * 26) / 10 + yy + yy / 4 + 6 * (yy / 100) + yy / 400) % 7;
    return (h + 6) % 7;
  endfunction

  // Expected calendar for a timestamp under the given hour mode.
  function automatic calendar_t calendar_of(input logic [31:0] secs, input bit mode24);
    int unsigned days;
    int unsigned rem;
    int unsigned year;
    int unsigned ylen;
    int unsigned m0;
    int unsigned hr;
    calendar_t   c;
    days = secs / SECS_PER_DAY;
    rem  = secs % SECS_PER_DAY;
    year = 1970;
    ylen = 365;
    // Peel off whole years, then whole months.
    while (days >= ylen) begin
      days = days - ylen;
      year = year + 1;
      ylen = leap_year(year) ? 366 : 365;
    end
    m0 = 0;
    while (m0 < 11 && days >= days_in_month(m0, year)) begin
      days = days - days_in_month(m0, year);
      m0 = m0 + 1;
    end
    hr = rem / 3600;
    // Twelve-hour display folds midnight to 12 and afternoon down by 12.
    if (!mode24) begin
      if (hr == 0) hr = 12;
      else if (hr > 12) hr = hr - 12;
    end
    c.second           = 6'((rem % 3600) % 60);
    c.minute           = 6'((rem % 3600) / 60);
    c.hour             = 5'(hr);
    c.day_of_month     = 5'(days + 1);
    c.month_index      = 4'(m0);
    c.years_since_1900 = 8'(year - 1900);
    c.weekday          = 3'(weekday_of(days + 1, m0 + 1, year));
    return c;
  endfunction

  // Timestamp of a calendar date and time plus an offset in seconds, kept in range.
  function automatic logic [31:0] stamp_of(input int y, input int m0, input int mday,
                                           input int h, input int mi, input int s,
                                           input int off);
    longint v;
    v = 0;
    for (int yy = 1970; yy < y; yy++) v = v + (leap_year(yy) ? 366 : 365);
    for (int mm = 0; mm < m0; mm++) v = v + days_in_month(mm, y);
    v = v + mday - 1;
    v = v * 86400 + h * 3600 + mi * 60 + s + off;
    if (v < 0) v = -v;
    if (v > STAMP_MAX) v = STAMP_MAX - longint'($urandom_range(100000));
    return v[31:0];
  endfunction

  // Random timestamp, weighted towards year, month, day and hour boundaries.
  function automatic logic [31:0] random_stamp();
    int y;
    int m;
    int d;
    int h;
    int off;
    y = $urandom_range(2106, 1970);
    m = $urandom_range(11);
    d = $urandom_range(days_in_month(m, y), 1);
    off = int'($urandom_range(6)) - 3;
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3, 4, 5: return stamp_of(y, m, d, $urandom_range(23), $urandom_range(59),
                               $urandom_range(59), 0);
      6, 7: begin
        if ($urandom_range(1) == 1) off = off * 86400;
        return stamp_of(y, ($urandom_range(1) == 1) ? 0 : m, 1, 0, 0, 0, off);
      end
      8: begin
        case ($urandom_range(4))
          0: h = 0;
          1: h = 11;
          2: h = 12;
          3: h = 13;
          default: h = 23;
        endcase
        return stamp_of(y, m, d, h, ($urandom_range(1) == 1) ? 59 : 0,
                        $urandom_range(59), off);
      end
      default: begin
        if ($urandom_range(1) == 1) return $urandom_range(200000);
        return 32'hFFFF_FFFF - $urandom_range(200000);
      end
    endcase
  endfunction

  task automatic queue_stamp(input logic [31:0] v);
    pending_stamps.push_back(v);
    items_queued++;
  endtask

  // Wait until every queued timestamp is taken and every calendar has come out.
  task automatic wait_drained();
    while (items_accepted != items_queued || calendar_due.size() != 0) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    // Of the addresses used here, only address zero holds a register; writes to the others are dropped.
    if (addr == ADDR_HOUR_MODE) hour_mode_24 = data[0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Read hour_mode back and compare it with the expected setting.
  task automatic check_hour_mode();
    logic [31:0] got;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_HOUR_MODE;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    if (got[0] !== hour_mode_24) begin
      $error("hour_mode readback: expected %0d, actual %0d", hour_mode_24, got[0]);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_hour_mode(input bit mode);
    apb_write(ADDR_HOUR_MODE, {31'($urandom_range(32'h7FFF_FFFF)), mode});
    check_hour_mode();
  endtask

  // One random phase under the given flow-control mix.
  task automatic run_random(input int n, input int unsigned send_pct,
                            input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n; i++) queue_stamp(random_stamp());
    wait_drained();
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer queued timestamps, with random gaps; stall the result side at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_stamps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid        <= 1'b1;
        in_ch.unix_seconds <= pending_stamps.pop_front();
      end else begin
        in_ch.valid        <= 1'b0;
        in_ch.unix_seconds <= $urandom;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Predict on each accepted timestamp and check each accepted calendar.
  always @(posedge clk) begin : monitor_blk
    calendar_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        calendar_due.push_back(calendar_of(in_ch.unix_seconds, hour_mode_24));
        items_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (calendar_due.size() == 0) begin
          $error("calendar item arrived with none expected");
          fail_count++;
        end else begin
          want = calendar_due.pop_front();
          check_field("second", want.second, out_ch.second);
          check_field("minute", want.minute, out_ch.minute);
          check_field("hour", want.hour, out_ch.hour);
          check_field("day_of_month", want.day_of_month, out_ch.day_of_month);
          check_field("month_index", want.month_index, out_ch.month_index);
          check_field("years_since_1900", want.years_since_1900, out_ch.years_since_1900);
          check_field("weekday", want.weekday, out_ch.weekday);
          results_checked++;
        end
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.unix_seconds = '0;
    out_ch.ready       = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The register should come out of reset in 24-hour mode.
    check_hour_mode();

    // Directed 24-hour items: epoch, unit rollovers, leap days, century years, top of range.
    queue_stamp(32'd0);
    queue_stamp(32'd1);
    queue_stamp(32'd3599);
    queue_stamp(32'd3600);
    queue_stamp(32'd86399);
    queue_stamp(32'd86400);
    queue_stamp(stamp_of(1970, 11, 31, 23, 59, 59, 0));
    queue_stamp(stamp_of(1972, 1, 29, 12, 0, 0, 0));
    queue_stamp(stamp_of(2000, 1, 29, 0, 0, 0, 0));
    queue_stamp(stamp_of(2100, 1, 28, 23, 59, 59, 0));
    queue_stamp(stamp_of(2100, 2, 1, 0, 0, 0, 0));
    queue_stamp(32'h7FFF_FFFF);
    queue_stamp(32'h8000_0000);
    queue_stamp(32'hFFFF_FFFE);
    queue_stamp(32'hFFFF_FFFF);
    wait_drained();

    // Directed 12-hour items around midnight, noon and the afternoon fold.
    set_hour_mode(MODE_12H);
    queue_stamp(stamp_of(2024, 5, 15, 0, 0, 0, 0));
    queue_stamp(stamp_of(2024, 5, 15, 0, 59, 59, 0));
    queue_stamp(stamp_of(2024, 5, 15, 11, 59, 59, 0));
    queue_stamp(stamp_of(2024, 5, 15, 12, 0, 0, 0));
    queue_stamp(stamp_of(2024, 5, 15, 12, 59, 59, 0));
    queue_stamp(stamp_of(2024, 5, 15, 13, 0, 0, 0));
    queue_stamp(stamp_of(2024, 5, 15, 23, 59, 59, 0));
    queue_stamp(32'hFFFF_FFFF);
    wait_drained();

    // A write to an address with no register must leave hour_mode alone.
    apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    check_hour_mode();

    run_random(238, 0, 0);
    set_hour_mode(MODE_24H);
    run_random(238, 55, 0);
    set_hour_mode(MODE_12H);
    run_random(238, 0, 55);
    set_hour_mode(MODE_24H);
    run_random(238, 36, 36);

    // Let any stray result surface before the verdict.
    repeat (300) @(posedge clk);

    $display("Checked %0d calendar items from %0d timestamps in both hour modes",
             results_checked, items_accepted);
    $display("under four flow-control mixes, with register readbacks; %0d failures.",
             fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #24_000_000;
    $display("Watchdog expired with %0d calendar items outstanding.", calendar_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
